// File: rtl/dsdp_pkg.sv
package dsdp_pkg;

  // default word width of a parsed number
  localparam int WORD_BITS_DEF = 16;

  // result queue depth, a power of two of at least 2
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_LVL_W = $clog2(RQ_DEPTH + 1);

  // character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // directive kind
  typedef enum logic {
    MODE_DATA = 1'b0,
    MODE_STR  = 1'b1
  } mode_t;

  // string scan phase
  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_INSIDE = 2'd1,
    PH_AFTER  = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  // line status codes
  typedef enum logic [3:0] {
    ST_OK             = 4'd0,
    ST_NO_DIGIT       = 4'd1,
    ST_LEAD_COMMA     = 4'd2,
    ST_DOUBLE_COMMA   = 4'd3,
    ST_BAD_AFTER_NUM  = 4'd4,
    ST_COMMA_NO_NEXT  = 4'd5,
    ST_SIGN_NO_DIGIT  = 4'd6,
    ST_SIGN_AFTER_NUM = 4'd7,
    ST_BAD_DATA_CHAR  = 4'd8,
    ST_TRAIL_COMMA    = 4'd9,
    ST_NO_STRING      = 4'd10,
    ST_NO_OPEN_QUOTE  = 4'd11,
    ST_BAD_STR_CHAR   = 4'd12,
    ST_NO_CLOSE_QUOTE = 4'd13,
    ST_EMPTY_STRING   = 4'd14,
    ST_TEXT_AFTER_STR = 4'd15
  } status_t;

  // one result beat
  typedef struct packed {
    logic signed [15:0] value;
    status_t            status;
    logic               last;
  } res_t;

  // results produced by one input beat, first in r0
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_run(input logic [7:0] c);
    return is_numeral(c) || is_sign(c);
  endfunction

endpackage

// File: rtl/data_string_directive_parser.sv
// Operand line parser for integer-list and quoted-string data directives.
// One character beat is accepted per cycle while the result queue has room,
// into a registered input stage; from that register the character is checked
// against the previous one, and the number accumulator or string phase is
// updated as it leaves the register, which pushes zero, one or two result
// beats into a four-entry result queue. Result beats drain one per cycle
// while out_ready is high, and a newline that closes a number pushes two
// beats (word plus status); input ready drops only when the queue has fewer
// than two free entries. The status beat (last = 1) ends each line; words
// before it are to be kept only when that status is zero.
module data_string_directive_parser
  import dsdp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_ch,
  input  logic               in_func,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_value,
  output logic [3:0]         out_status,
  output logic               out_last
);

  push_t               push;
  logic                space_ok;
  logic [RQ_LVL_W-1:0] q_level;

  // character parser
  dsdp_parse #(
    .WORD_BITS(WORD_BITS)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .in_func  (in_func),
    .space_ok (space_ok),
    .push     (push)
  );

  // result queue
  dsdp_resq u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .space_ok   (space_ok),
    .level      (q_level),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status),
    .out_last   (out_last)
  );

`ifndef SYNTH
  // queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= RQ_LVL_W'(RQ_DEPTH))
    else $error("result queue overflow");

  // status beats carry a zero value
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_value == 16'sd0))
    else $error("status beat with nonzero value");

  // word beats carry status ok
  a_word_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == ST_OK))
    else $error("word beat with nonzero status");
`endif

endmodule

// File: rtl/dsdp_parse.sv
module dsdp_parse
  import dsdp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_func,
  input  logic       space_ok,
  output push_t      push
);

  // input register
  logic       ivld_r;
  logic [7:0] ch_r;
  logic       func_r;

  // line state
  mode_t                line_mode_r, line_mode_nxt;
  logic [7:0]           prev_char_r, prev_char_nxt;
  logic                 prev_valid_r, prev_valid_nxt;
  logic                 in_number_r, in_number_nxt;
  logic                 comma_seen_r, comma_seen_nxt;
  logic                 digit_seen_r, digit_seen_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic                 neg_r, neg_nxt;
  status_t              first_error_r, first_error_nxt;
  phase_t               phase_r, phase_nxt;
  logic                 nonempty_r, nonempty_nxt;

  // parse logic signals
  logic                        fire;
  mode_t                       mode;
  logic                        nl;
  logic                        prev_run;
  status_t                     err_code;
  status_t                     err_all;
  status_t                     line_status;
  logic                        emit;
  logic signed [15:0]          word;
  logic [WORD_BITS-1:0]        acc_base;
  logic [WORD_BITS+3:0]        acc_prod;
  logic [WORD_BITS-1:0]        wrd;
  logic signed [31:0]          wrd_ext;
  res_t                        res_word;
  res_t                        res_stat;

  assign fire     = ivld_r && space_ok;
  assign in_ready = !ivld_r || space_ok;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
    end else if (in_ready) begin
      ivld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      ch_r   <= in_ch;
      func_r <= in_func;
    end
  end

  // decimal accumulate and signed wrap of the current run
  assign acc_base = prev_run ? acc_r : '0;
  assign acc_prod = {acc_base, 3'b000} + {2'b00, acc_base, 1'b0}
                  + (WORD_BITS+4)'(ch_r - CH_ZERO);
  assign wrd      = neg_r ? (~acc_r + 1'b1) : acc_r;
  assign wrd_ext  = 32'(signed'(wrd));

  // character rules and state update
  always_comb begin
    mode           = prev_valid_r ? line_mode_r : mode_t'(func_r);
    nl             = (ch_r == CH_NL);
    prev_run       = prev_valid_r && is_run(prev_char_r);
    err_code       = ST_OK;
    emit           = 1'b0;
    word           = '0;
    line_mode_nxt  = line_mode_r;
    prev_char_nxt  = prev_char_r;
    prev_valid_nxt = prev_valid_r;
    in_number_nxt  = in_number_r;
    comma_seen_nxt = comma_seen_r;
    digit_seen_nxt = digit_seen_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    phase_nxt      = phase_r;
    nonempty_nxt   = nonempty_r;

    if (mode == MODE_DATA) begin
      // previous character checked against this one
      if (prev_valid_r) begin
        if (is_blank(prev_char_r)) begin
          if (!in_number_r) begin
            if (ch_r == CH_COMMA) begin
              err_code = comma_seen_r ? ST_DOUBLE_COMMA : ST_LEAD_COMMA;
            end
          end else if (!(is_blank(ch_r) || nl || ch_r == CH_COMMA)) begin
            err_code = ST_BAD_AFTER_NUM;
          end
        end else if (prev_char_r == CH_COMMA) begin
          if (!in_number_r) begin
            err_code = comma_seen_r ? ST_DOUBLE_COMMA : ST_LEAD_COMMA;
          end else if (ch_r == CH_COMMA || nl) begin
            err_code = ST_COMMA_NO_NEXT;
          end else begin
            in_number_nxt = 1'b0;
          end
          comma_seen_nxt = 1'b1;
        end else if (is_sign(prev_char_r)) begin
          if (!is_numeral(ch_r)) begin
            err_code = ST_SIGN_NO_DIGIT;
          end
        end else if (is_numeral(prev_char_r)) begin
          if (is_sign(ch_r)) begin
            err_code = ST_SIGN_AFTER_NUM;
          end else begin
            in_number_nxt = 1'b1;
          end
        end else begin
          err_code = ST_BAD_DATA_CHAR;
        end
      end
      // end of a number run
      if (prev_run && !is_run(ch_r)) begin
        emit = 1'b1;
        word = wrd_ext[15:0];
      end
      // start or extend a number run
      if (is_run(ch_r)) begin
        if (!prev_run) begin
          acc_nxt = '0;
          neg_nxt = (ch_r == CH_MINUS);
        end
        if (is_numeral(ch_r)) begin
          acc_nxt        = acc_prod[WORD_BITS-1:0];
          digit_seen_nxt = 1'b1;
        end
      end
    end else if (!nl) begin
      unique case (phase_r)
        PH_BEFORE: begin
          if (ch_r == CH_QUOTE) begin
            phase_nxt = PH_INSIDE;
          end else if (!is_blank(ch_r)) begin
            err_code  = ST_NO_OPEN_QUOTE;
            phase_nxt = PH_STOP;
          end
        end
        PH_INSIDE: begin
          if (ch_r == CH_QUOTE) begin
            if (!nonempty_r) begin
              err_code = ST_EMPTY_STRING;
            end
            emit      = 1'b1;
            phase_nxt = PH_AFTER;
          end else if ((ch_r >= CH_SPACE && ch_r <= CH_TILDE) || ch_r == CH_TAB) begin
            emit         = 1'b1;
            word         = {8'h00, ch_r};
            nonempty_nxt = 1'b1;
          end else begin
            err_code  = ST_BAD_STR_CHAR;
            phase_nxt = PH_STOP;
          end
        end
        PH_AFTER: begin
          if (!is_blank(ch_r)) begin
            err_code  = ST_TEXT_AFTER_STR;
            phase_nxt = PH_STOP;
          end
        end
        PH_STOP: begin
        end
        default: begin
        end
      endcase
    end else begin
      // string line ends
      if (phase_r == PH_BEFORE) begin
        err_code = ST_NO_STRING;
      end else if (phase_r == PH_INSIDE) begin
        err_code = ST_NO_CLOSE_QUOTE;
      end
    end

    // first error wins
    err_all = (first_error_r == ST_OK) ? err_code : first_error_r;

    // line status, no digit overrides in data mode
    if (mode == MODE_DATA) begin
      if (!digit_seen_nxt) begin
        line_status = ST_NO_DIGIT;
      end else if (err_all != ST_OK) begin
        line_status = err_all;
      end else begin
        line_status = in_number_nxt ? ST_OK : ST_TRAIL_COMMA;
      end
    end else begin
      line_status = err_all;
    end

    first_error_nxt = err_all;
    if (nl) begin
      line_mode_nxt   = MODE_DATA;
      prev_char_nxt   = '0;
      prev_valid_nxt  = 1'b0;
      in_number_nxt   = 1'b0;
      comma_seen_nxt  = 1'b0;
      digit_seen_nxt  = 1'b0;
      acc_nxt         = '0;
      neg_nxt         = 1'b0;
      first_error_nxt = ST_OK;
      phase_nxt       = PH_BEFORE;
      nonempty_nxt    = 1'b0;
    end else begin
      line_mode_nxt  = mode;
      prev_char_nxt  = ch_r;
      prev_valid_nxt = 1'b1;
    end
  end

  // result beats of this character
  always_comb begin
    res_word.value  = word;
    res_word.status = ST_OK;
    res_word.last   = 1'b0;
    res_stat.value  = '0;
    res_stat.status = line_status;
    res_stat.last   = 1'b1;
    push.cnt        = fire ? ({1'b0, emit} + {1'b0, nl}) : 2'd0;
    push.r0         = emit ? res_word : res_stat;
    push.r1         = res_stat;
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_mode_r   <= MODE_DATA;
      prev_char_r   <= '0;
      prev_valid_r  <= 1'b0;
      in_number_r   <= 1'b0;
      comma_seen_r  <= 1'b0;
      digit_seen_r  <= 1'b0;
      acc_r         <= '0;
      neg_r         <= 1'b0;
      first_error_r <= ST_OK;
      phase_r       <= PH_BEFORE;
      nonempty_r    <= 1'b0;
    end else if (fire) begin
      line_mode_r   <= line_mode_nxt;
      prev_char_r   <= prev_char_nxt;
      prev_valid_r  <= prev_valid_nxt;
      in_number_r   <= in_number_nxt;
      comma_seen_r  <= comma_seen_nxt;
      digit_seen_r  <= digit_seen_nxt;
      acc_r         <= acc_nxt;
      neg_r         <= neg_nxt;
      first_error_r <= first_error_nxt;
      phase_r       <= phase_nxt;
      nonempty_r    <= nonempty_nxt;
    end
  end

endmodule

// File: rtl/dsdp_resq.sv
module dsdp_resq
  import dsdp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  push_t               push,
  output logic                space_ok,
  output logic [RQ_LVL_W-1:0] level,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_value,
  output logic [3:0]          out_status,
  output logic                out_last
);

  res_t                mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_LVL_W-1:0] level_r, level_nxt;
  logic                pop;
  logic [RQ_PTR_W-1:0] wr_ptr_p1;

  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign space_ok  = (level_r <= RQ_LVL_W'(RQ_DEPTH - 2));
  assign level     = level_r;

  // head of queue
  assign out_valid  = (level_r != '0);
  assign out_value  = mem[rd_ptr_r].value;
  assign out_status = mem[rd_ptr_r].status;
  assign out_last   = mem[rd_ptr_r].last;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RQ_PTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + RQ_PTR_W'(pop);
    level_nxt  = level_r + RQ_LVL_W'(push.cnt) - RQ_LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // store up to two beats
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

endmodule

// File: sim/data_string_directive_parser_tb.sv
import dsdp_pkg::*;

// line parser scoreboard: tracks the parse state of the current line and
// holds the result beats still owed by the block
class parse_scoreboard;
  mode_t       line_mode;
  logic [7:0]  prev_char;
  bit          prev_valid;
  bit          in_number;
  bit          comma_seen;
  bit          digit_seen;
  logic [15:0] number_acc;
  bit          number_negative;
  status_t     first_error;
  phase_t      string_phase;
  bit          string_nonempty;

  res_t        owed_beats[$];
  int          errors;
  int          chars;
  int          words;
  int          lines;
  int          beats;
  bit [15:0]   status_seen;

  function new();
    errors = 0;
    chars = 0;
    words = 0;
    lines = 0;
    beats = 0;
    status_seen = '0;
    clear_line();
  endfunction

  function void clear_line();
    line_mode = MODE_DATA;
    prev_char = '0;
    prev_valid = 0;
    in_number = 0;
    comma_seen = 0;
    digit_seen = 0;
    number_acc = '0;
    number_negative = 0;
    first_error = ST_OK;
    string_phase = PH_BEFORE;
    string_nonempty = 0;
  endfunction

  // character classes
  function bit num_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function bit blank_char(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function bit sign_char(logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS;
  endfunction

  function bit run_char(logic [7:0] c);
    return num_digit(c) || sign_char(c);
  endfunction

  // only the first error of a line sticks
  function void flag(status_t code);
    if (first_error == ST_OK) first_error = code;
  endfunction

  function status_t comma_error();
    if (comma_seen) return ST_DOUBLE_COMMA;
    return ST_LEAD_COMMA;
  endfunction

  function void owe(logic [15:0] v, status_t s, bit l);
    res_t r;
    r.value = v;
    r.status = s;
    r.last = l;
    owed_beats.push_back(r);
  endfunction

  // integer-list rules on character c with lookahead nx
  function void check_data(logic [7:0] c, logic [7:0] nx);
    if (blank_char(c)) begin
      if (!in_number) begin
        if (nx == CH_COMMA) flag(comma_error());
      end else if (!(blank_char(nx) || nx == CH_NL || nx == CH_COMMA)) begin
        flag(ST_BAD_AFTER_NUM);
      end
    end else if (c == CH_COMMA) begin
      if (!in_number) flag(comma_error());
      else if (nx == CH_COMMA || nx == CH_NL) flag(ST_COMMA_NO_NEXT);
      else in_number = 0;
      comma_seen = 1;
    end else if (sign_char(c)) begin
      if (!num_digit(nx)) flag(ST_SIGN_NO_DIGIT);
    end else if (num_digit(c)) begin
      if (sign_char(nx)) flag(ST_SIGN_AFTER_NUM);
      else in_number = 1;
    end else begin
      flag(ST_BAD_DATA_CHAR);
    end
  endfunction

  // accepted input beat: advance the line state, queue what it produces
  function void note_char(logic [7:0] ch, logic f);
    mode_t       mode;
    bit          nl;
    bit          prev_run;
    status_t     st;
    logic [15:0] word;
    mode = prev_valid ? line_mode : mode_t'(f);
    nl = (ch == CH_NL);
    chars++;
    if (mode == MODE_DATA) begin
      prev_run = prev_valid && run_char(prev_char);
      if (prev_valid) check_data(prev_char, ch);
      // a run of signs and digits ends here
      if (prev_run && !run_char(ch)) begin
        word = number_negative ? -number_acc : number_acc;
        owe(word, ST_OK, 0);
      end
      if (run_char(ch)) begin
        if (!prev_run) begin
          number_acc = '0;
          number_negative = (ch == CH_MINUS);
        end
        if (num_digit(ch)) begin
          number_acc = number_acc * 16'd10 + {8'd0, ch - CH_ZERO};
          digit_seen = 1;
        end
      end
    end else if (!nl) begin
      case (string_phase)
        PH_BEFORE: begin
          if (ch == CH_QUOTE) begin
            string_phase = PH_INSIDE;
          end else if (!blank_char(ch)) begin
            flag(ST_NO_OPEN_QUOTE);
            string_phase = PH_STOP;
          end
        end
        PH_INSIDE: begin
          if (ch == CH_QUOTE) begin
            if (!string_nonempty) flag(ST_EMPTY_STRING);
            owe('0, ST_OK, 0);
            string_phase = PH_AFTER;
          end else if ((ch >= CH_SPACE && ch <= CH_TILDE) || ch == CH_TAB) begin
            owe({8'd0, ch}, ST_OK, 0);
            string_nonempty = 1;
          end else begin
            flag(ST_BAD_STR_CHAR);
            string_phase = PH_STOP;
          end
        end
        PH_AFTER: begin
          if (!blank_char(ch)) begin
            flag(ST_TEXT_AFTER_STR);
            string_phase = PH_STOP;
          end
        end
        default: ;
      endcase
    end

    if (!nl) begin
      line_mode = mode;
      prev_char = ch;
      prev_valid = 1;
      return;
    end

    // newline: status beat, no digit overrides everything in data mode
    if (mode == MODE_DATA) begin
      if (!digit_seen) st = ST_NO_DIGIT;
      else if (first_error != ST_OK) st = first_error;
      else if (in_number) st = ST_OK;
      else st = ST_TRAIL_COMMA;
    end else begin
      if (string_phase == PH_BEFORE) flag(ST_NO_STRING);
      else if (string_phase == PH_INSIDE) flag(ST_NO_CLOSE_QUOTE);
      st = first_error;
    end
    owe('0, st, 1);
    lines++;
    clear_line();
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 30) $display("mismatch: %s", msg);
  endtask

  // accepted result beat against the oldest owed beat
  task check_result(logic signed [15:0] v, logic [3:0] s, logic l);
    res_t want;
    beats++;
    if (owed_beats.size() == 0) begin
      report($sformatf("beat %0d: value %0d status %0d last %0d with nothing owed",
                       beats, v, s, l));
      return;
    end
    want = owed_beats.pop_front();
    if (v !== want.value)
      report($sformatf("beat %0d: value %0d, expected %0d", beats, v, want.value));
    if (s !== want.status)
      report($sformatf("beat %0d: status %0d, expected %0d", beats, s, want.status));
    if (l !== want.last)
      report($sformatf("beat %0d: last %0d, expected %0d", beats, l, want.last));
    if (want.last) status_seen[want.status] = 1'b1;
    else words++;
  endtask
endclass

module data_string_directive_parser_tb;

  localparam int PERIOD       = 20;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_CHARS = 1800;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 20;

  typedef enum {LINE_DATA, LINE_STRING, LINE_MUTATED, LINE_NOISE} line_kind_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_ch = '0;
  logic               in_func = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_value;
  logic [3:0]         out_status;
  logic               out_last;

  parse_scoreboard sb;
  logic [7:0]      line_q[$];
  bit              steady = 1'b0;
  int              chars_sent = 0;
  int              stall_cycles = 0;

  always #(PERIOD / 2) clk = ~clk;

  data_string_directive_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_ch     (in_ch),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .out_status(out_status),
    .out_last  (out_last)
  );

  // result side stalls about a quarter of the time
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 25);
  end

  // beat monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_char(in_ch, in_func);
      if (out_valid && out_ready) sb.check_result(out_value, out_status, out_last);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic f);
    while (!steady && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= ch;
    in_func <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  // send the built line plus newline; mix varies func past the first char
  task automatic send_line(input mode_t f, input bit mix);
    logic fb;
    line_q.push_back(CH_NL);
    foreach (line_q[i]) begin
      fb = (mix && i > 0) ? 1'($urandom_range(1)) : f;
      send_char(line_q[i], fb);
    end
    in_valid <= 1'b0;
    line_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic add_blanks(input int maxn);
    repeat ($urandom_range(maxn)) line_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
  endtask

  // well-formed number list with random signs, lengths and blanks
  task automatic build_numbers();
    int nums;
    int nd;
    nums = $urandom_range(1, 5);
    add_blanks(2);
    for (int k = 0; k < nums; k++) begin
      if (k > 0) begin
        add_blanks(1);
        line_q.push_back(CH_COMMA);
        add_blanks(1);
      end
      case ($urandom_range(3))
        0: line_q.push_back(CH_PLUS);
        1: line_q.push_back(CH_MINUS);
        default: ;
      endcase
      nd = ($urandom_range(15) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      repeat (nd) line_q.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
    add_blanks(2);
  endtask

  // well-formed quoted string, now and then empty
  task automatic build_quoted();
    logic [7:0] c;
    int         n;
    n = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 8);
    add_blanks(2);
    line_q.push_back(CH_QUOTE);
    repeat (n) begin
      c = 8'($urandom_range(CH_SPACE, CH_TILDE));
      if (c == CH_QUOTE) c = CH_TAB;
      line_q.push_back(c);
    end
    line_q.push_back(CH_QUOTE);
    add_blanks(2);
  endtask

  // random byte leaning toward the characters the rules care about
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return CH_COMMA;
      1: return CH_PLUS;
      2: return CH_MINUS;
      3: return CH_SPACE;
      4: return CH_TAB;
      5: return CH_QUOTE;
      6: return CH_ZERO + 8'($urandom_range(9));
      7: return CH_NL;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic run_random_line();
    line_kind_t kind;
    mode_t      f;
    int         pick;
    int         pos;
    pick = $urandom_range(99);
    if (pick < 40) kind = LINE_DATA;
    else if (pick < 70) kind = LINE_STRING;
    else if (pick < 87) kind = LINE_MUTATED;
    else kind = LINE_NOISE;
    f = mode_t'($urandom_range(1));
    case (kind)
      LINE_DATA: begin
        f = MODE_DATA;
        build_numbers();
      end
      LINE_STRING: begin
        f = MODE_STR;
        build_quoted();
      end
      LINE_MUTATED: begin
        if (f == MODE_DATA) build_numbers();
        else build_quoted();
        pos = $urandom_range(line_q.size() - 1);
        if ($urandom_range(1)) line_q[pos] = pick_byte();
        else line_q.insert(pos, pick_byte());
      end
      default: repeat ($urandom_range(6)) line_q.push_back(pick_byte());
    endcase
    send_line(f, kind == LINE_NOISE);
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // empty lines in both modes
    send_line(MODE_DATA, 1'b0);
    send_line(MODE_STR, 1'b0);
    // empty string still emits its zero word
    add_text("\"\"");
    send_line(MODE_STR, 1'b0);
    // number wrapping at the word width, negative number
    add_text("99999,-1");
    send_line(MODE_DATA, 1'b0);
    // top printable char, then a byte above it
    add_text("\"~");
    line_q.push_back(8'hFF);
    send_line(MODE_STR, 1'b0);
    // leading comma and a sign-only run: no digit wins
    add_text(",+");
    send_line(MODE_DATA, 1'b0);
    // control char after a number, word still goes out
    add_text("1");
    line_q.push_back(8'h00);
    send_line(MODE_DATA, 1'b0);

    // random lines, one stretch with no idling on either side
    while (chars_sent < RANDOM_CHARS) begin
      steady <= (chars_sent > 700 && chars_sent < 1100);
      run_random_line();
    end
    steady <= 1'b0;

    while (sb.owed_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.owed_beats.size() != 0)
      sb.report($sformatf("%0d result beats never arrived", sb.owed_beats.size()));

    $display("parsed %0d characters over %0d lines, %0d data words checked",
             sb.chars, sb.lines, sb.words);
    $display("%0d of 16 line status codes observed", $countones(sb.status_seen));
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
